[src/integer_field_formatter_macros.svh]
// assertion macros for the integer field formatter
`ifndef INTEGER_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
`define IFF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer_field_formatter: implication check failed");
`define IFF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_field_formatter: next-cycle check failed");
`else
`define IFF_ASSERT_IMP(label, clk, rst, ante, cons)
`define IFF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[src/iff_pkg.sv]
// shared constants, types and helpers of the integer field formatter
`timescale 1ns / 1ps
package iff_pkg;
   localparam int MAX_WIDTH     = 48;
   localparam int MAX_PRECISION = 32;
   localparam int MAX_RESULTS   = 48;
   localparam int VALUE_W       = 64;
   localparam int FIELD_W       = 6;
   localparam int NUM_DIGITS    = 22;
   localparam int DIGIT_W       = 4;
   localparam int SIG_W         = $clog2(NUM_DIGITS + 1);
   localparam int LEN_W         = $clog2(MAX_WIDTH + MAX_PRECISION + NUM_DIGITS + 3);
   localparam int BITCNT_W      = $clog2(VALUE_W + 1);
   localparam int CHAR_W        = 8;
   localparam int REQ_DATA_W    = 88;
   localparam int REQ_USER_W    = 5;

   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_HEXL = 3'd2;
   localparam logic [2:0] MODE_HEXU = 3'd3;
   localparam logic [2:0] MODE_OCT  = 3'd4;

   localparam logic [1:0] SIZE_32 = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_64 = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS      = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X_LOW     = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_X_UP      = 8'h58;
   localparam logic [CHAR_W-1:0] HEX_LOW_OFFSET = 8'd87;
   localparam logic [CHAR_W-1:0] HEX_UP_OFFSET  = 8'd55;

   typedef enum logic [1:0] {
      BASE_DEC,
      BASE_HEX,
      BASE_OCT
   } base_type;

   typedef struct packed {
      logic               done;
      logic [SIG_W-1:0]   sig;
      logic [DIGIT_W-1:0] digit;
   } conv_status_type;

   typedef struct packed {
      logic busy;
      logic finish;
      logic pop;
   } emit_status_type;

   typedef struct packed {
      base_type           base;
      logic               sdec;
      logic               upper;
      logic               neg;
      logic               flag_left;
      logic               flag_plus;
      logic               flag_space;
      logic               flag_alt;
      logic               flag_zero;
      logic               has_precision;
      logic [FIELD_W-1:0] precision;
      logic [FIELD_W-1:0] width;
   } job_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < DIGIT_W'(10)) begin
         return CHAR_ZERO + d_ext;
      end else begin
         return d_ext + (upper ? HEX_UP_OFFSET : HEX_LOW_OFFSET);
      end
   endfunction
endpackage

[src/integer_field_formatter.sv]
// top level of the integer field formatter: request capture, sign handling, assertions
//
//  channel | direction | contents
//  req     | in        | tdata: value, flags, precision, width; tuser: mode, size_sel
//  rsp     | out       | tdata: out_char; tlast: last character of the field
//
// one request at a time; req_tready stays low until busy_ff clears on the emitter's
// finish, which follows the last character being loaded into the output register
// decimal conversion runs 64 bcd steps, hex and octal load the digits directly; up
// to 22 leading zero digits are then dropped before the characters are emitted
// rsp_tready low stalls the character sequencer; synchronous reset clears busy, start,
// launch, both state machines and the output valid flag
`timescale 1ns / 1ps
`include "integer_field_formatter_macros.svh"
module integer_field_formatter
   import iff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // value[63:0], flag_left, flag_plus, flag_space, flag_alt, flag_zero,
   // has_precision, precision[5:0], width[5:0], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[2:0], size_sel[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_char[7:0]
   output logic [CHAR_W-1:0]     rsp_tdata,
   output logic                  rsp_tlast
);
   logic                  busy_ff, busy_in;
   logic                  start_ff, start_in;
   logic                  launch_ff, launch_in;
   logic [REQ_DATA_W-1:0] data_ff;
   logic [REQ_USER_W-1:0] user_ff;

   logic                  req_accept;
   logic                  em_start;
   logic [2:0]            mode;
   logic [1:0]            size_sel;
   logic [VALUE_W-1:0]    value;
   logic [VALUE_W-1:0]    mask;
   logic [VALUE_W-1:0]    masked;
   logic [VALUE_W-1:0]    mag;
   logic                  sign_bit;
   base_type              base;
   logic                  sdec;
   job_type               job;
   conv_status_type       conv_stat;
   emit_status_type       em_stat;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;

   assign mode     = user_ff[2:0];
   assign size_sel = user_ff[4:3];
   assign value    = data_ff[VALUE_W-1:0];

   always_comb begin
      case (mode)
         MODE_SDEC: begin
            base = BASE_DEC;
            sdec = 1'b1;
         end
         MODE_HEXL, MODE_HEXU: begin
            base = BASE_HEX;
            sdec = 1'b0;
         end
         MODE_OCT: begin
            base = BASE_OCT;
            sdec = 1'b0;
         end
         MODE_UDEC: begin
            base = BASE_DEC;
            sdec = 1'b0;
         end
         default: begin
            base = BASE_DEC;
            sdec = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (size_sel)
         SIZE_16: begin
            mask     = VALUE_W'(16'hFFFF);
            sign_bit = value[15];
         end
         SIZE_32: begin
            mask     = VALUE_W'(32'hFFFF_FFFF);
            sign_bit = value[31];
         end
         SIZE_64: begin
            mask     = '1;
            sign_bit = value[VALUE_W-1];
         end
         default: begin
            mask     = '1;
            sign_bit = value[VALUE_W-1];
         end
      endcase
      masked = value & mask;
      mag    = (sdec && sign_bit) ? ((VALUE_W'(0) - masked) & mask) : masked;
   end

   always_comb begin
      job.base          = base;
      job.sdec          = sdec;
      job.upper         = (mode == MODE_HEXU);
      job.neg           = sdec && sign_bit;
      job.flag_left     = data_ff[64];
      job.flag_plus     = data_ff[65];
      job.flag_space    = data_ff[66];
      job.flag_alt      = data_ff[67];
      job.flag_zero     = data_ff[68];
      job.has_precision = data_ff[69];
      job.precision     = data_ff[75:70];
      job.width         = data_ff[81:76];
   end

   assign em_start = launch_ff && conv_stat.done;

   always_comb begin
      busy_in   = busy_ff;
      start_in  = 1'b0;
      launch_in = launch_ff;
      if (req_accept) begin
         busy_in  = 1'b1;
         start_in = 1'b1;
      end
      if (start_ff) begin
         launch_in = 1'b1;
      end else if (em_start) begin
         launch_in = 1'b0;
      end
      if (em_stat.finish) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         start_ff  <= 1'b0;
         launch_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         start_ff  <= start_in;
         launch_ff <= launch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         data_ff <= req_tdata;
         user_ff <= req_tuser;
      end
   end

   iff_digit_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .mag   (mag),
      .base  (base),
      .pop   (em_stat.pop),
      .stat  (conv_stat)
   );

   iff_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (em_start),
      .job        (job),
      .conv       (conv_stat),
      .stat       (em_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   `IFF_ASSERT_IMP(a_launch_in_busy, clock, reset, launch_ff, busy_ff)
   `IFF_ASSERT_IMP(a_emitter_in_busy, clock, reset, em_stat.busy, busy_ff)
   `IFF_ASSERT_NXT(a_start_clears_done, clock, reset, start_ff, !conv_stat.done)
   `IFF_ASSERT_IMP(a_pop_needs_digits, clock, reset, em_stat.pop, conv_stat.done)
endmodule

[src/iff_digit_conv.sv]
// bit-serial radix converter: shift-add-3 for decimal, direct load for hex and octal
`timescale 1ns / 1ps
module iff_digit_conv
   import iff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_W-1:0]    mag,
   input  base_type              base,
   input  logic                  pop,
   output conv_status_type       stat
);
   localparam int DIGS_W = NUM_DIGITS * DIGIT_W;
   localparam int OCT_W  = NUM_DIGITS * 3;

   typedef enum logic [1:0] {
      C_IDLE,
      C_DABBLE,
      C_NORM,
      C_DONE
   } conv_state_type;

   conv_state_type      state_ff, state_in;
   logic [DIGS_W-1:0]   dig_ff, dig_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [BITCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [SIG_W-1:0]    sig_ff, sig_in;

   logic [DIGS_W-1:0]   adj;
   logic [DIGS_W-1:0]   hex_load;
   logic [DIGS_W-1:0]   oct_load;
   logic [OCT_W-1:0]    mag_oct;
   logic [DIGS_W-1:0]   dig_shift;
   logic [DIGIT_W-1:0]  top_digit;

   // add 3 to every bcd digit of five or more before the shift
   always_comb begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (dig_ff[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adj[k*DIGIT_W +: DIGIT_W] = dig_ff[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            adj[k*DIGIT_W +: DIGIT_W] = dig_ff[k*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign hex_load = DIGS_W'(mag);
   assign mag_oct  = OCT_W'(mag);

   always_comb begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
         oct_load[k*DIGIT_W +: DIGIT_W] = DIGIT_W'(mag_oct[k*3 +: 3]);
      end
   end

   assign dig_shift = {dig_ff[DIGS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
   assign top_digit = dig_ff[DIGS_W-1 -: DIGIT_W];

   always_comb begin
      state_in   = state_ff;
      dig_in     = dig_ff;
      bin_in     = bin_ff;
      bit_cnt_in = bit_cnt_ff;
      sig_in     = sig_ff;
      if (start) begin
         sig_in = SIG_W'(NUM_DIGITS);
         case (base)
            BASE_HEX: begin
               dig_in   = hex_load;
               state_in = C_NORM;
            end
            BASE_OCT: begin
               dig_in   = oct_load;
               state_in = C_NORM;
            end
            default: begin
               dig_in     = '0;
               bin_in     = mag;
               bit_cnt_in = BITCNT_W'(VALUE_W);
               state_in   = C_DABBLE;
            end
         endcase
      end else begin
         case (state_ff)
            C_DABBLE: begin
               dig_in     = {adj[DIGS_W-2:0], bin_ff[VALUE_W-1]};
               bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - BITCNT_W'(1);
               if (bit_cnt_ff == BITCNT_W'(1)) begin
                  state_in = C_NORM;
               end
            end
            C_NORM: begin
               // drop leading zero digits, counting what is left
               if (sig_ff == '0 || top_digit != '0) begin
                  state_in = C_DONE;
               end else begin
                  dig_in = dig_shift;
                  sig_in = sig_ff - SIG_W'(1);
               end
            end
            C_DONE: begin
               if (pop) begin
                  dig_in = dig_shift;
               end
            end
            default: begin
               state_in = C_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dig_ff     <= dig_in;
      bin_ff     <= bin_in;
      bit_cnt_ff <= bit_cnt_in;
      sig_ff     <= sig_in;
   end

   assign stat.done  = (state_ff == C_DONE);
   assign stat.sig   = sig_ff;
   assign stat.digit = top_digit;
endmodule

[src/iff_emitter.sv]
// field layout and output sequencer, one character at a time while the output slot is free
`timescale 1ns / 1ps
module iff_emitter
   import iff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  job_type               job,
   input  conv_status_type       conv,
   output emit_status_type       stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_W-1:0]     rsp_char,
   output logic                  rsp_last
);
   typedef enum logic [1:0] {
      E_IDLE,
      E_SIZE,
      E_LAYOUT,
      E_RUN
   } emit_state_type;

   typedef enum logic [2:0] {
      PH_PADL,
      PH_PRE,
      PH_PADZ,
      PH_ZERO,
      PH_DIG,
      PH_PADR
   } phase_type;

   emit_state_type      state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [LEN_W-1:0]    emitted_ff, emitted_in;
   logic [LEN_W-1:0]    total_ff, total_in;
   job_type             job_ff, job_in;
   logic [SIG_W-1:0]    ndig_ff, ndig_in;
   logic [LEN_W-1:0]    zeros_ff, zeros_in;
   logic [1:0]          npre_ff, npre_in;
   logic [2*CHAR_W-1:0] pre_ff, pre_in;
   logic [LEN_W-1:0]    padz_ff, padz_in;
   logic [LEN_W-1:0]    padr_ff, padr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]    prec_s;
   logic [SIG_W-1:0]    ndig_c;
   logic [LEN_W-1:0]    zeros_c;
   logic [1:0]          npre_c;
   logic [2*CHAR_W-1:0] pre_c;
   logic [LEN_W-1:0]    wid_s;
   logic [LEN_W-1:0]    body;
   logic [LEN_W-1:0]    pad;
   logic [LEN_W-1:0]    span;
   logic                zpad;
   logic                slot_free;
   logic                finish;
   logic                pop;
   logic [CHAR_W-1:0]   ch;

   // digit count, precision zeros and prefix
   always_comb begin
      if (LEN_W'(job_ff.precision) > LEN_W'(MAX_PRECISION)) begin
         prec_s = LEN_W'(MAX_PRECISION);
      end else begin
         prec_s = LEN_W'(job_ff.precision);
      end
      if (conv.sig != '0) begin
         ndig_c = conv.sig;
      end else if (job_ff.has_precision && job_ff.precision == '0) begin
         ndig_c = '0;
      end else begin
         ndig_c = SIG_W'(1);
      end
      zeros_c = (prec_s > LEN_W'(ndig_c)) ? prec_s - LEN_W'(ndig_c) : '0;
      npre_c  = 2'd0;
      pre_c   = '0;
      if (job_ff.sdec) begin
         if (job_ff.neg) begin
            npre_c = 2'd1;
            pre_c  = {CHAR_MINUS, CHAR_W'(0)};
         end else if (job_ff.flag_plus) begin
            npre_c = 2'd1;
            pre_c  = {CHAR_PLUS, CHAR_W'(0)};
         end else if (job_ff.flag_space) begin
            npre_c = 2'd1;
            pre_c  = {CHAR_SPACE, CHAR_W'(0)};
         end
      end else if (job_ff.flag_alt && job_ff.base == BASE_HEX && conv.sig != '0) begin
         npre_c = 2'd2;
         pre_c  = {CHAR_ZERO, job_ff.upper ? CHAR_X_UP : CHAR_X_LOW};
      end else if (job_ff.flag_alt && job_ff.base == BASE_OCT && zeros_c == '0 &&
                   (conv.sig != '0 || ndig_c == '0)) begin
         zeros_c = LEN_W'(1);
      end
   end

   // width padding and total length
   always_comb begin
      if (LEN_W'(job_ff.width) > LEN_W'(MAX_WIDTH)) begin
         wid_s = LEN_W'(MAX_WIDTH);
      end else begin
         wid_s = LEN_W'(job_ff.width);
      end
      body = LEN_W'(npre_ff) + zeros_ff + LEN_W'(ndig_ff);
      pad  = (wid_s > body) ? wid_s - body : '0;
      span = body + pad;
      zpad = !job_ff.flag_left && job_ff.flag_zero && !job_ff.has_precision;
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      emitted_in   = emitted_ff;
      total_in     = total_ff;
      job_in       = job_ff;
      ndig_in      = ndig_ff;
      zeros_in     = zeros_ff;
      npre_in      = npre_ff;
      pre_in       = pre_ff;
      padz_in      = padz_ff;
      padr_in      = padr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      finish       = 1'b0;
      pop          = 1'b0;
      ch           = CHAR_SPACE;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               job_in   = job;
               state_in = E_SIZE;
            end
         end
         E_SIZE: begin
            ndig_in  = ndig_c;
            zeros_in = zeros_c;
            npre_in  = npre_c;
            pre_in   = pre_c;
            state_in = E_LAYOUT;
         end
         E_LAYOUT: begin
            padz_in    = zpad ? pad : '0;
            padr_in    = job_ff.flag_left ? pad : '0;
            total_in   = (span > LEN_W'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : span;
            emitted_in = '0;
            phase_in   = PH_PADL;
            cnt_in     = (!job_ff.flag_left && !zpad) ? pad : '0;
            state_in   = E_RUN;
         end
         E_RUN: begin
            if (emitted_ff == total_ff) begin
               finish   = 1'b1;
               state_in = E_IDLE;
            end else if (cnt_ff == '0) begin
               case (phase_ff)
                  PH_PADL: begin
                     phase_in = PH_PRE;
                     cnt_in   = LEN_W'(npre_ff);
                  end
                  PH_PRE: begin
                     phase_in = PH_PADZ;
                     cnt_in   = padz_ff;
                  end
                  PH_PADZ: begin
                     phase_in = PH_ZERO;
                     cnt_in   = zeros_ff;
                  end
                  PH_ZERO: begin
                     phase_in = PH_DIG;
                     cnt_in   = LEN_W'(ndig_ff);
                  end
                  PH_DIG: begin
                     phase_in = PH_PADR;
                     cnt_in   = padr_ff;
                  end
                  default: begin
                     finish   = 1'b1;
                     state_in = E_IDLE;
                  end
               endcase
            end else if (slot_free) begin
               case (phase_ff)
                  PH_PRE: begin
                     ch     = pre_ff[2*CHAR_W-1 -: CHAR_W];
                     pre_in = {pre_ff[CHAR_W-1:0], CHAR_W'(0)};
                  end
                  PH_PADZ, PH_ZERO: begin
                     ch = CHAR_ZERO;
                  end
                  PH_DIG: begin
                     ch  = digit_char(conv.digit, job_ff.upper);
                     pop = 1'b1;
                  end
                  default: begin
                     ch = CHAR_SPACE;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_char_in  = ch;
               rsp_last_in  = (emitted_ff + LEN_W'(1) == total_ff);
               cnt_in       = cnt_ff - LEN_W'(1);
               emitted_in   = emitted_ff + LEN_W'(1);
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff    <= phase_in;
      cnt_ff      <= cnt_in;
      emitted_ff  <= emitted_in;
      total_ff    <= total_in;
      job_ff      <= job_in;
      ndig_ff     <= ndig_in;
      zeros_ff    <= zeros_in;
      npre_ff     <= npre_in;
      pre_ff      <= pre_in;
      padz_ff     <= padz_in;
      padr_ff     <= padr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.busy   = (state_ff != E_IDLE);
   assign stat.finish = finish;
   assign stat.pop    = pop;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_char    = rsp_char_ff;
   assign rsp_last    = rsp_last_ff;
endmodule

[tb/sv/tb_integer_field_formatter.sv]
// self-checking testbench for the integer field formatter: directed and random requests
`timescale 1ns / 1ps
module tb_integer_field_formatter;
   import iff_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_COUNT = 450;

   // flag groups, {left, plus, space, alt, zero}
   localparam logic [4:0] FL_NONE  = 5'b00000;
   localparam logic [4:0] FL_LEFT  = 5'b10000;
   localparam logic [4:0] FL_PLUS  = 5'b01000;
   localparam logic [4:0] FL_SPACE = 5'b00100;
   localparam logic [4:0] FL_ALT   = 5'b00010;
   localparam logic [4:0] FL_ZERO  = 5'b00001;

   localparam logic [2:0] MODE_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] MODE_UNKNOWN_HI = 3'd7;
   localparam logic [1:0] SIZE_UNKNOWN    = 2'd3;

   typedef struct {
      logic [2:0]         mode;
      logic [1:0]         size_sel;
      logic [63:0]        value;
      logic               flag_left;
      logic               flag_plus;
      logic               flag_space;
      logic               flag_alt;
      logic               flag_zero;
      logic               has_precision;
      logic [FIELD_W-1:0] precision;
      logic [FIELD_W-1:0] field_width;
   } format_request_type;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
   } field_char_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [CHAR_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;

   field_char_type expected_chars[$];
   int             mismatches    = 0;
   int             chars_checked = 0;
   int             requests_sent = 0;
   int             empty_fields  = 0;
   int             cycle_count   = 0;
   bit             idle_on       = 1;
   bit             long_hold     = 0;

   integer_field_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: timeout, %0d characters still expected", $time, expected_chars.size());
      $display("integer_field_formatter: mismatch");
      $finish;
   end

   // expected text of one request, leftmost character first
   function automatic void format_field(input format_request_type r);
      logic [2:0]        mode;
      logic              upper;
      logic              neg;
      logic              zero_fill;
      logic [63:0]       mag;
      logic [63:0]       rest;
      logic [63:0]       radix;
      logic [CHAR_W-1:0] digit_code;
      logic [CHAR_W-1:0] digits[$];
      logic [CHAR_W-1:0] prefix[$];
      logic [CHAR_W-1:0] text[$];
      field_char_type    fc;
      int                prec;
      int                wid;
      int                d;
      int                zeros;
      int                pad;
      int                count;
      mode  = r.mode;
      upper = (mode == MODE_HEXU);
      neg   = 1'b0;
      if (mode > MODE_OCT) mode = MODE_UDEC;
      prec = (r.precision > MAX_PRECISION) ? MAX_PRECISION : int'(r.precision);
      wid  = (r.field_width > MAX_WIDTH) ? MAX_WIDTH : int'(r.field_width);

      if (r.size_sel == SIZE_32) begin
         mag = {32'b0, r.value[31:0]};
         if (mode == MODE_SDEC && mag[31]) begin
            neg = 1'b1;
            mag = 64'h1_0000_0000 - mag;
         end
      end else if (r.size_sel == SIZE_16) begin
         mag = {48'b0, r.value[15:0]};
         if (mode == MODE_SDEC && mag[15]) begin
            neg = 1'b1;
            mag = 64'h1_0000 - mag;
         end
      end else begin
         mag = r.value;
         if (mode == MODE_SDEC && mag[63]) begin
            neg = 1'b1;
            mag = 64'd0 - mag;
         end
      end

      if (mode == MODE_HEXL || mode == MODE_HEXU) radix = 64'd16;
      else if (mode == MODE_OCT) radix = 64'd8;
      else radix = 64'd10;

      rest = mag;
      while (rest != 0) begin
         d = int'(rest % radix);
         if (d < 10) digit_code = CHAR_ZERO + CHAR_W'(d);
         else digit_code = CHAR_W'(d) + (upper ? HEX_UP_OFFSET : HEX_LOW_OFFSET);
         digits.push_front(digit_code);
         rest = rest / radix;
      end
      if (digits.size() == 0 && !(r.has_precision && prec == 0)) digits.push_back(CHAR_ZERO);
      zeros = (prec > digits.size()) ? prec - digits.size() : 0;

      if (mode == MODE_SDEC) begin
         if (neg) prefix.push_back(CHAR_MINUS);
         else if (r.flag_plus) prefix.push_back(CHAR_PLUS);
         else if (r.flag_space) prefix.push_back(CHAR_SPACE);
      end else if (r.flag_alt && radix == 16 && mag != 0) begin
         prefix.push_back(CHAR_ZERO);
         prefix.push_back(upper ? CHAR_X_UP : CHAR_X_LOW);
      end else if (r.flag_alt && radix == 8 && zeros == 0 && (mag != 0 || digits.size() == 0)) begin
         zeros = 1;
      end

      pad = wid - (prefix.size() + zeros + digits.size());
      if (pad < 0) pad = 0;
      zero_fill = r.flag_zero && !r.has_precision;

      if (!r.flag_left && !zero_fill) repeat (pad) text.push_back(CHAR_SPACE);
      foreach (prefix[k]) text.push_back(prefix[k]);
      if (!r.flag_left && zero_fill) repeat (pad) text.push_back(CHAR_ZERO);
      repeat (zeros) text.push_back(CHAR_ZERO);
      foreach (digits[k]) text.push_back(digits[k]);
      if (r.flag_left) repeat (pad) text.push_back(CHAR_SPACE);

      count = (text.size() > MAX_RESULTS) ? MAX_RESULTS : text.size();
      if (count == 0) empty_fields++;
      for (int k = 0; k < count; k++) begin
         fc.code = text[k];
         fc.last = (k + 1 == count);
         expected_chars.push_back(fc);
      end
   endfunction

   function automatic format_request_type build_request(input logic [2:0] mode,
                                                        input logic [1:0] size_sel,
                                                        input logic [63:0] value,
                                                        input logic [4:0] flags,
                                                        input logic has_precision,
                                                        input int precision,
                                                        input int field_width);
      format_request_type r;
      r.mode          = mode;
      r.size_sel      = size_sel;
      r.value         = value;
      r.flag_left     = flags[4];
      r.flag_plus     = flags[3];
      r.flag_space    = flags[2];
      r.flag_alt      = flags[1];
      r.flag_zero     = flags[0];
      r.has_precision = has_precision;
      r.precision     = FIELD_W'(precision);
      r.field_width   = FIELD_W'(field_width);
      return r;
   endfunction

   task automatic send_request(input format_request_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r.field_width, r.precision, r.has_precision, r.flag_zero,
                     r.flag_alt, r.flag_space, r.flag_plus, r.flag_left, r.value};
      req_tuser  <= {r.size_sel, r.mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      format_field(r);
      requests_sent++;
   endtask

   // output side: random stalls per character, one long hold on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            stall     = HOLD_CYCLES;
            long_hold = 0;
         end else begin
            stall = idle_on ? $urandom_range(0, 11) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // compare each output transaction with the oldest expected character
   always @(posedge clock) begin
      field_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected character, expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_tdata !== want.code) begin
               mismatches++;
               $display("%0t ns: out_char expected %h actual %h", $time, want.code, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               mismatches++;
               $display("%0t ns: last expected %b actual %b", $time, want.last, rsp_tlast);
            end
         end
      end
   end

   task automatic test_size_extremes();
      send_request(build_request(MODE_SDEC, SIZE_32, 64'h0000_0000_8000_0000, FL_NONE, 0, 0, 0));
      send_request(build_request(MODE_SDEC, SIZE_32, 64'hFFFF_FFFF_7FFF_FFFF, FL_PLUS, 0, 0, 0));
      send_request(build_request(MODE_SDEC, SIZE_16, 64'hFFFF_FFFF_FFFF_8000, FL_NONE, 0, 0, 0));
      send_request(build_request(MODE_SDEC, SIZE_16, 64'h1234_5678_9ABC_7FFF, FL_SPACE, 0, 0, 0));
      send_request(build_request(MODE_SDEC, SIZE_64, 64'h8000_0000_0000_0000, FL_NONE, 0, 0, 0));
      send_request(build_request(MODE_SDEC, SIZE_64, '1, FL_NONE, 0, 0, 0));
      send_request(build_request(MODE_UDEC, SIZE_64, '1, FL_NONE, 0, 0, 0));
      send_request(build_request(MODE_UDEC, SIZE_UNKNOWN, '1, FL_NONE, 0, 0, 0));
      send_request(build_request(MODE_OCT, SIZE_64, '1, FL_ALT, 0, 0, 0));
   endtask

   task automatic test_conversions();
      send_request(build_request(MODE_HEXL, SIZE_64, 64'hDEAD_BEEF_0123_ABCD, FL_ALT, 0, 0, 0));
      send_request(build_request(MODE_HEXU, SIZE_64, 64'hDEAD_BEEF_0123_ABCD, FL_ALT, 0, 0, 0));
      send_request(build_request(MODE_OCT, SIZE_32, 64'h0000_0000_0000_01FF, FL_ALT, 0, 0, 0));
      send_request(build_request(MODE_UNKNOWN_LO, SIZE_32, 64'hFFFF_FFFF, FL_PLUS, 0, 0, 0));
      send_request(build_request(MODE_UNKNOWN_HI, SIZE_16, 64'h8000, FL_SPACE, 0, 0, 6));
      send_request(build_request(MODE_HEXL, SIZE_32, 64'hFF, FL_PLUS | FL_SPACE, 0, 0, 0));
   endtask

   task automatic test_padding();
      send_request(build_request(MODE_SDEC, SIZE_32, 64'hFFFF_FFD6, FL_ZERO, 0, 0, 10));
      send_request(build_request(MODE_SDEC, SIZE_32, 64'hFFFF_FFD6, FL_ZERO, 1, 5, 10));
      send_request(build_request(MODE_SDEC, SIZE_32, 64'd42, FL_LEFT | FL_ZERO | FL_PLUS, 0, 0, 8));
      send_request(build_request(MODE_HEXL, SIZE_64, '1, FL_ALT | FL_ZERO, 0, 0, 63));
      send_request(build_request(MODE_UDEC, SIZE_64, 64'd7, FL_LEFT, 1, 63, 63));
   endtask

   task automatic test_zero_values();
      send_request(build_request(MODE_SDEC, SIZE_32, 64'd0, FL_NONE, 1, 0, 0));
      send_request(build_request(MODE_OCT, SIZE_32, 64'd0, FL_ALT, 1, 0, 0));
      send_request(build_request(MODE_HEXL, SIZE_32, 64'd0, FL_ALT, 0, 0, 4));
      send_request(build_request(MODE_UDEC, SIZE_64, 64'd0, FL_NONE, 1, 0, 3));
   endtask

   // output held off while requests keep coming
   task automatic test_output_backpressure();
      idle_on   = 0;
      long_hold = 1;
      repeat (6) begin
         send_request(build_request(MODE_SDEC, SIZE_64, {$urandom, $urandom}, FL_NONE, 0, 0, 40));
      end
      idle_on = 1;
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          shift;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 20));
         2: v = 64'd0;
         3: v = '1 - 64'($urandom_range(0, 3));
         4: begin
            case ($urandom_range(0, 2))
               0: shift = 15;
               1: shift = 31;
               default: shift = 63;
            endcase
            v = (64'd1 << shift) + 64'($urandom_range(0, 3)) - 64'd2;
         end
         default: v = {{32{1'b1}}, $urandom};
      endcase
      return v;
   endfunction

   function automatic format_request_type random_request();
      format_request_type r;
      int pick;
      pick   = $urandom_range(0, 15);
      r.mode = (pick < 14) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
      r.size_sel      = 2'($urandom_range(0, 3));
      r.value         = random_value();
      r.flag_left     = 1'($urandom_range(0, 1));
      r.flag_plus     = 1'($urandom_range(0, 1));
      r.flag_space    = 1'($urandom_range(0, 1));
      r.flag_alt      = 1'($urandom_range(0, 1));
      r.flag_zero     = 1'($urandom_range(0, 1));
      r.has_precision = 1'($urandom_range(0, 1));
      r.precision = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                : 6'($urandom_range(0, 32));
      case ($urandom_range(0, 7))
         0:       r.field_width = 6'($urandom_range(49, 63));
         1, 2, 3: r.field_width = 6'($urandom_range(0, 12));
         default: r.field_width = 6'($urandom_range(0, 48));
      endcase
      return r;
   endfunction

   task automatic test_random_requests();
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         idle_on = ((i / 40) % 4) != 3;
         send_request(random_request());
      end
      idle_on = 1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_size_extremes();
      test_conversions();
      test_padding();
      test_zero_values();
      test_output_backpressure();
      test_random_requests();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over all conversions, sizes, flags, precisions and widths",
               requests_sent);
      $display("%0d characters checked, %0d empty fields, %0d cycles",
               chars_checked, empty_fields, cycle_count);
      if (mismatches == 0) begin
         $display("integer_field_formatter: match");
      end else begin
         $display("integer_field_formatter: mismatch");
      end
      $finish;
   end
endmodule
